/* hdl/sme_pkg.sv */
// Shared types and constants for the sparse matrix stream encoder.
// No dependencies; imported by every module of the block.
package sme_pkg;

  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;
  localparam int POS_W = 26;
  localparam int WORD_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_W-1:0] MAX_COLS = 13'd4096;
  localparam logic [COUNT_W-1:0] MAX_ROWS = 13'd4096;
  localparam logic [WORD_W-1:0] ROW_FLAG = 32'h8000_0000;

  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  typedef struct packed {
    logic hdr;
    logic mark;
    logic nz;
    logic [COUNT_W-1:0] cols;
    logic [COUNT_W-1:0] rows;
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_COLS,
    PH_ROWS,
    PH_MARK,
    PH_COL,
    PH_VAL
  } phase_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] maxv);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hdl/sme_front.sv */
// Front end: accepts elements, tracks matrix position and word count, and
// queues a descriptor of the words each element causes. Depends on sme_pkg.
module sme_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [31:0]             s_tdata,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [sme_pkg::COUNT_W-1:0] num_cols,
  input  logic [sme_pkg::COUNT_W-1:0] num_rows,
  input  logic                    q_full,
  output logic                    q_push,
  output sme_pkg::entry_t         q_wdata
);
  import sme_pkg::*;

  logic [INDEX_W-1:0] col_counter;
  logic [INDEX_W-1:0] row_counter;
  logic row_marked;
  logic header_sent;
  logic [POS_W-1:0] word_counter;

  logic [COUNT_W-1:0] cols_eff;
  logic [COUNT_W-1:0] rows_eff;
  logic accept;
  logic hdr;
  logic nz;
  logic mark;
  logic [POS_W-1:0] start_pos;
  logic [2:0] nwords;
  logic col_last;
  logic row_last;

  assign cols_eff = clamp_count(num_cols, MAX_COLS);
  assign rows_eff = clamp_count(num_rows, MAX_ROWS);
  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign hdr = !header_sent;
  assign nz = (s_tdata != '0);
  assign mark = nz && !row_marked;
  assign start_pos = hdr ? '0 : word_counter;
  assign nwords = {hdr, 1'b0} + {2'b00, mark} + {nz, 1'b0};
  assign col_last = ({1'b0, col_counter} + COUNT_W'(1)) >= cols_eff;
  assign row_last = ({1'b0, row_counter} + COUNT_W'(1)) >= rows_eff;

  assign q_push = accept && (nwords != '0);
  always_comb begin
    q_wdata.hdr = hdr;
    q_wdata.mark = mark;
    q_wdata.nz = nz;
    q_wdata.cols = cols_eff;
    q_wdata.rows = rows_eff;
    q_wdata.row = row_counter;
    q_wdata.col = col_counter;
    q_wdata.value = s_tdata;
    q_wdata.pos = start_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
      row_marked <= 1'b0;
      header_sent <= 1'b0;
      word_counter <= '0;
    end else if (accept) begin
      word_counter <= start_pos + POS_W'(nwords);
      if (col_last) begin
        col_counter <= '0;
        row_marked <= 1'b0;
        if (row_last) begin
          row_counter <= '0;
          header_sent <= 1'b0;
        end else begin
          row_counter <= row_counter + INDEX_W'(1);
          header_sent <= 1'b1;
        end
      end else begin
        col_counter <= col_counter + INDEX_W'(1);
        header_sent <= 1'b1;
        if (mark) begin
          row_marked <= 1'b1;
        end
      end
    end
  end

  a_push_has_words: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_wdata.hdr || q_wdata.nz))
    else $error("queued descriptor causes no word");

endmodule

/* hdl/sme_queue.sv */
// Short descriptor queue between the front end and the word generator.
// Depends on sme_pkg.
module sme_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sme_pkg::entry_t wdata,
  input  logic            pop,
  output sme_pkg::entry_t rdata,
  output logic            full,
  output logic            empty
);
  import sme_pkg::*;

  entry_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0] count;
  qctl_t ctl;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];
  assign ctl = '{push: push, pop: pop, full: full, empty: empty};

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (ctl.pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(ctl.push) - (QPTR_W+1)'(ctl.pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.full |-> !ctl.push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctl.empty |-> !ctl.pop)
    else $error("pop from empty queue");

endmodule

/* hdl/sme_back.sv */
// Word generator: expands the queue head into output words, one per cycle while
// the output accepts them, into a registered output stage. Depends on sme_pkg.
module sme_back (
  input  logic                clk,
  input  logic                rst,
  input  sme_pkg::entry_t     head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic [63:0]         m_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_tlast
);
  import sme_pkg::*;

  phase_t phase;
  phase_t phase_next;
  phase_t cur;
  logic [2:0] offset;
  logic load;
  logic last;
  logic [WORD_W-1:0] word;
  logic [POS_W-1:0] pos;

  assign load = !q_empty && (!m_tvalid || m_tready);
  assign pos = head.pos + POS_W'(offset);
  assign q_pop = load && last;

  always_comb begin
    if (phase == PH_START) begin
      cur = head.hdr ? PH_COLS : (head.mark ? PH_MARK : PH_COL);
    end else begin
      cur = phase;
    end
    last = 1'b0;
    phase_next = PH_START;
    word = '0;
    case (cur)
      PH_COLS: begin
        word = WORD_W'(head.cols);
        phase_next = PH_ROWS;
      end
      PH_ROWS: begin
        word = WORD_W'(head.rows);
        if (head.mark) begin
          phase_next = PH_MARK;
        end else if (head.nz) begin
          phase_next = PH_COL;
        end else begin
          last = 1'b1;
        end
      end
      PH_MARK: begin
        word = ROW_FLAG | WORD_W'(head.row);
        phase_next = PH_COL;
      end
      PH_COL: begin
        word = WORD_W'(head.col);
        phase_next = PH_VAL;
      end
      PH_VAL: begin
        word = head.value;
        last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      offset <= '0;
    end else if (load) begin
      if (last) begin
        phase <= PH_START;
        offset <= '0;
      end else begin
        phase <= phase_next;
        offset <= offset + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'b0, pos, word};
      m_tlast <= last;
    end
  end

  a_phase_has_head: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_START) |-> !q_empty)
    else $error("word generator mid-descriptor with empty queue");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    offset <= 3'd4)
    else $error("more than five words from one descriptor");

endmodule

/* hdl/sparse_matrix_stream_encoder.sv */
// Sparse matrix stream encoder top level: configuration registers, front end,
// descriptor queue and word generator. Depends on sme_pkg and its submodules.
// An accepted element's descriptor is registered in the queue, its words in the output stage.
// Throughput: one word out per cycle unless m_tready stalls; a nonzero element takes 2 to 5
// words, a zero one two if it opens a matrix, else none; one element in per cycle while the queue has room.
// Reset is synchronous: counters clear, num_cols and num_rows return to 1, the queue empties.
module sparse_matrix_stream_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] s_tdata,   // [31:0] element_value
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic [63:0] m_tdata,   // [31:0] stream_word, [57:32] word_position
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sme_pkg::*;

  logic [COUNT_W-1:0] num_cols;
  logic [COUNT_W-1:0] num_rows;
  logic wr_en;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  entry_t q_wdata;
  entry_t q_rdata;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= COUNT_W'(1);
      num_rows <= COUNT_W'(1);
    end else if (wr_en) begin
      if (paddr[2] == REG_NUM_COLS) begin
        num_cols <= pwdata[COUNT_W-1:0];
      end else begin
        num_rows <= pwdata[COUNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NUM_ROWS) ? 32'(num_rows) : 32'(num_cols);

  sme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .num_cols (num_cols),
    .num_rows (num_rows),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sme_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  sme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
  );

endmodule
